// ===== hw/rtl/scp_pkg.sv =====
// scp_pkg: shared types and constants for the second-chance page replacement block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package scp_pkg;

    // built defaults for the top-level parameters
    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // fixed field widths of the stream payloads
    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 3;
    localparam int EVICT_PAGE_W  = 16;
    localparam int FAULT_TOTAL_W = 32;
    localparam int S_TDATA_W     = 16;
    localparam int M_RESULT_W    = 1 + FRAME_INDEX_W + 1 + EVICT_PAGE_W + FAULT_TOTAL_W;
    localparam int M_TDATA_W     = ((M_RESULT_W + 7) / 8) * 8;
    localparam int M_PAD_W       = M_TDATA_W - M_RESULT_W;

    // frames_in_use register
    localparam int             CFG_W     = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } scp_state_t;

endpackage

// ===== hw/rtl/scp_page_ram.sv =====
// scp_page_ram: frame page-number store, one write port and one registered read port
// uses scp_pkg
`timescale 1ns / 1ps

module scp_page_ram
    import scp_pkg::*;
#(
    parameter int DEPTH  = NUM_FRAMES_DEF,
    parameter int WIDTH  = PAGE_BITS_DEF,
    parameter int ADDR_W = $clog2(NUM_FRAMES_DEF)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/scp_step_unit.sv =====
// scp_step_unit: shared page compare and wrapping frame-index step
// uses scp_pkg; used by the sequencer for both the lookup scan and the hand sweep
`timescale 1ns / 1ps

module scp_step_unit
    import scp_pkg::*;
#(
    parameter int IDX_W  = $clog2(NUM_FRAMES_DEF),
    parameter int CNT_W  = $clog2(NUM_FRAMES_DEF + 1),
    parameter int PAGE_W = PAGE_BITS_DEF
) (
    input  logic [IDX_W-1:0]  idx,
    input  logic [CNT_W-1:0]  active_frames,
    input  logic [PAGE_W-1:0] page_a,
    input  logic [PAGE_W-1:0] page_b,
    output logic              page_match,
    output logic              idx_last,
    output logic [IDX_W-1:0]  idx_wrap
);

    logic [CNT_W-1:0] idx_inc;

    always_comb begin
        idx_inc    = CNT_W'(idx) + CNT_W'(1);
        idx_last   = (idx_inc >= active_frames);
        idx_wrap   = idx_last ? '0 : IDX_W'(idx_inc);
        page_match = (page_a == page_b);
    end

endmodule

// ===== hw/rtl/second_chance_page_replacement.sv =====
// second_chance_page_replacement: clock (second-chance) page replacement over a frame table
// uses scp_pkg, scp_page_ram, scp_step_unit
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata[15:0] page_number
// m_        out  m_tvalid / m_tready       s_tdata-style packed result, see port list
// cfg_      in   cfg_valid / cfg_ready     cfg_data[3:0] frames_in_use
//
// a hit on frame i holds the input side while frames 0..i are scanned; a miss holds it
//   while all n active frames are scanned and s frames are passed over (0..n) in the sweep
// the single compare/step unit visits one frame a cycle, and the page store has only
// one read port
// reset: aresetn low clears all frames, the hand, the fault count and the register to 3
// a result waits in the output register; the next transfer is taken meanwhile and
//   holds in its final state only if the output register is still full

module second_chance_page_replacement
    import scp_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] page_number
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] fault, [3:1] frame_index,
                                            // [4] evicted_valid, [20:5] evicted_page,
                                            // [52:21] fault_total, [55:53] zero
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data   // frames_in_use
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);

    // sequencer and state registers
    scp_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        cfg_reg;
    logic [PAGE_BITS-1:0]    page_reg, page_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        hand_reg, hand_next;
    logic [NUM_FRAMES-1:0]   valid_reg, valid_next;
    logic [NUM_FRAMES-1:0]   ref_reg, ref_next;
    logic [FAULT_TOTAL_W-1:0] fault_cnt_reg, fault_cnt_next;

    // pending result
    logic                    res_fault_reg, res_fault_next;
    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic                    res_ev_valid_reg, res_ev_valid_next;
    logic [PAGE_BITS-1:0]    res_ev_page_reg, res_ev_page_next;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // page store port
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [PAGE_BITS-1:0]    ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [PAGE_BITS-1:0]    ram_rdata;

    // shared step unit
    logic [CNT_W-1:0]        active_frames;
    logic                    step_match;
    logic                    step_last;
    logic [IDX_W-1:0]        step_wrap;
    logic [IDX_W-1:0]        hand_start;

    scp_page_ram #(
        .DEPTH  (NUM_FRAMES),
        .WIDTH  (PAGE_BITS),
        .ADDR_W (IDX_W)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    scp_step_unit #(
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .PAGE_W (PAGE_BITS)
    ) u_step (
        .idx           (idx_reg),
        .active_frames (active_frames),
        .page_a        (ram_rdata),
        .page_b        (page_reg),
        .page_match    (step_match),
        .idx_last      (step_last),
        .idx_wrap      (step_wrap)
    );

    // effective frame count: zero acts as one, too large clamps to the built count
    always_comb begin
        if (32'(cfg_reg) >= NUM_FRAMES) begin
            active_frames = CNT_W'(NUM_FRAMES);
        end else if (cfg_reg == '0) begin
            active_frames = CNT_W'(1);
        end else begin
            active_frames = CNT_W'(cfg_reg);
        end
    end

    // hand left beyond a lowered count restarts at frame 0
    assign hand_start = (CNT_W'(hand_reg) >= active_frames) ? '0 : hand_reg;

    // configuration register, written only while the block is idle
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hand_reg      <= '0;
            valid_reg     <= '0;
            ref_reg       <= '0;
            fault_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            fault_cnt_reg <= fault_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        page_reg         <= page_next;
        idx_reg          <= idx_next;
        res_fault_reg    <= res_fault_next;
        res_idx_reg      <= res_idx_next;
        res_ev_valid_reg <= res_ev_valid_next;
        res_ev_page_reg  <= res_ev_page_next;
        m_tdata_reg      <= m_tdata_next;
    end

    always_comb begin
        state_next        = state_reg;
        page_next         = page_reg;
        idx_next          = idx_reg;
        hand_next         = hand_reg;
        valid_next        = valid_reg;
        ref_next          = ref_reg;
        fault_cnt_next    = fault_cnt_reg;
        res_fault_next    = res_fault_reg;
        res_idx_next      = res_idx_reg;
        res_ev_valid_next = res_ev_valid_reg;
        res_ev_page_next  = res_ev_page_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        ram_wdata         = page_reg;
        ram_raddr         = idx_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // take the reference and start reading frame 0
                if (s_tvalid) begin
                    page_next  = PAGE_BITS'(s_tdata[PAGE_NUMBER_W-1:0]);
                    idx_next   = '0;
                    ram_raddr  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data holds frame idx_reg; lowest matching frame wins
                if (valid_reg[idx_reg] && step_match) begin
                    ref_next[idx_reg] = 1'b1;
                    res_fault_next    = 1'b0;
                    res_idx_next      = idx_reg;
                    res_ev_valid_next = 1'b0;
                    res_ev_page_next  = '0;
                    state_next        = ST_DONE;
                end else if (step_last) begin
                    // miss: the sweep starts at the hand
                    idx_next   = hand_start;
                    state_next = ST_SWEEP;
                end else begin
                    idx_next  = step_wrap;
                    ram_raddr = step_wrap;
                end
            end
            ST_SWEEP: begin
                // referenced frames get their second chance
                if (ref_reg[idx_reg]) begin
                    ref_next[idx_reg] = 1'b0;
                    idx_next          = step_wrap;
                end else begin
                    // victim found; its old page is read now
                    ram_raddr  = idx_reg;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                ram_we            = 1'b1;
                ram_waddr         = idx_reg;
                ram_wdata         = page_reg;
                valid_next[idx_reg] = 1'b1;
                ref_next[idx_reg] = 1'b1;
                hand_next         = step_wrap;
                fault_cnt_next    = fault_cnt_reg + FAULT_TOTAL_W'(1);
                res_fault_next    = 1'b1;
                res_idx_next      = idx_reg;
                res_ev_valid_next = valid_reg[idx_reg];
                res_ev_page_next  = valid_reg[idx_reg] ? ram_rdata : '0;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                // move the result into the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        {M_PAD_W{1'b0}},
                        fault_cnt_reg,
                        EVICT_PAGE_W'(res_ev_page_reg),
                        res_ev_valid_reg,
                        FRAME_INDEX_W'(res_idx_reg),
                        res_fault_reg
                    };
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/scp_checker.sv =====
// scp_checker: port-level assertions for the second-chance page replacement block
// uses scp_pkg; bound to second_chance_page_replacement below
`timescale 1ns / 1ps

module scp_checker
    import scp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a hit reports no eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[20:4] == 17'd0)
        else $error("hit result carries an evicted page");

    // an empty victim reports page zero
    a_empty_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[20:5] == 16'd0)
        else $error("evicted page nonzero without a loaded page");

    // one reference at a time: the input side closes after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a reference is in progress");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind second_chance_page_replacement scp_checker u_scp_checker (.*);
